// ===== rtl/merge_sort_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Merge sort engine assertion macros
// Shared assertion forms, clocked on the rising edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Property that must hold at every sampled edge outside reset.
`define MSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define MSE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// Merge sort engine package
// Shared widths, types and defaults for the sorter cell chain.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned ValueW          = 32;
  localparam int unsigned DefMaxElements  = 64;

  typedef logic signed [ValueW-1:0] mse_value_t;

  // One slot of the sorted chain.
  typedef struct packed {
    logic       valid;
    mse_value_t value;
  } mse_entry_t;

  // Per-cycle command broadcast to all cells.
  typedef struct packed {
    logic ins;  // insert the new value into the sorted chain
    logic pop;  // shift the chain one slot toward cell 0
  } mse_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } mse_state_e;

endpackage

// ===== rtl/mse_if.sv =====
// ----------------------------------------------------------------------------
// Merge sort engine channels
// Valid/ready interfaces for the input and the result streams.
// ----------------------------------------------------------------------------
interface mse_in_if;
  import mse_pkg::*;

  logic       valid;
  logic       ready;
  mse_value_t value_in;
  logic       last_in;

  modport source (output valid, output value_in, output last_in, input ready);
  modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface mse_out_if;
  import mse_pkg::*;

  logic       valid;
  logic       ready;
  mse_value_t value_out;
  logic       last_out;
  logic       dropped;

  modport source (output valid, output value_out, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input value_out, input last_out, input dropped,
                  output ready);
endinterface

// ===== rtl/mse_cell.sv =====
// ----------------------------------------------------------------------------
// Merge sort engine cell
// One slot of the sorted chain: compares the new value against its own,
// takes the value, its left neighbor's entry, or its right neighbor's entry.
// ----------------------------------------------------------------------------
module mse_cell import mse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mse_ctrl_t  ctrl_i,
  input  mse_value_t new_value_i,
  input  mse_entry_t left_entry_i,
  input  logic       left_shift_i,
  input  mse_entry_t right_entry_i,
  output mse_entry_t entry_o,
  output logic       shift_o
);

  logic       valid_q, valid_d;
  mse_value_t value_q, value_d;

  // Empty slots act as +infinity; strict less keeps ties in arrival order.
  assign shift_o = !valid_q || (new_value_i < value_q);
  assign entry_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.pop) begin
      valid_d = right_entry_i.valid;
      value_d = right_entry_i.value;
    end else if (ctrl_i.ins && shift_o) begin
      if (left_shift_i) begin
        valid_d = left_entry_i.valid;
        value_d = left_entry_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== rtl/merge_sort_engine.sv =====
// Loading: one element per cycle while in_i.valid is high; the first result is shown
// the cycle after the transaction carrying last_in, then one result per cycle while
// out_o.ready is high. The insertion chain takes no new set until the whole run
// has been emitted.
// Reset: all cells empty, element count and overflow flag cleared, ready to load.
// ----------------------------------------------------------------------------
// Merge sort engine top level
// Stable ascending sorter built as a chain of insertion cells.
// ----------------------------------------------------------------------------
`include "merge_sort_engine_assert.svh"

module merge_sort_engine import mse_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = DefMaxElements
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MAX_ELEMENTS + 1);

  mse_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             overflow_q, overflow_d;
  mse_ctrl_t        ctrl;
  logic             in_acc, out_acc, buf_full;

  mse_entry_t       entry_w [MAX_ELEMENTS];
  logic             shift_w [MAX_ELEMENTS];

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign buf_full = (count_q == CntW'(MAX_ELEMENTS));

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    mse_entry_t left_e, right_e;
    logic       left_s;

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_s = shift_w[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_end
      assign right_e = '0;
    end else begin : g_next
      assign right_e = entry_w[i+1];
    end

    mse_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (in_i.value_in),
      .left_entry_i (left_e),
      .left_shift_i (left_s),
      .right_entry_i(right_e),
      .entry_o      (entry_w[i]),
      .shift_o      (shift_w[i])
    );
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    overflow_d = overflow_q;
    ctrl       = '0;
    in_i.ready = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          if (buf_full) begin
            overflow_d = 1'b1;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CntW'(1);
          end
          if (in_i.last_in) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          ctrl.pop = 1'b1;
          if (out_o.last_out) begin
            state_d    = ST_LOAD;
            count_d    = '0;
            overflow_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_o.valid     = (state_q == ST_EMIT) && entry_w[0].valid;
  assign out_o.value_out = entry_w[0].value;
  assign out_o.last_out  = !entry_w[1].valid;
  assign out_o.dropped   = overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  `MSE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_ELEMENTS), "element count beyond depth")
  `MSE_ASSERT(a_emit_nonempty, clk_i, rst_ni, (state_q == ST_EMIT) |-> entry_w[0].valid, "emitting from an empty chain")
  `MSE_ASSERT_NEXT(a_last_starts_emit, clk_i, rst_ni, in_acc && in_i.last_in, state_q == ST_EMIT, "final element did not start emission")
  `MSE_ASSERT_NEXT(a_run_end_clears, clk_i, rst_ni, out_acc && out_o.last_out, (state_q == ST_LOAD) && (count_q == '0) && !entry_w[0].valid && !overflow_q, "state not cleared after the run")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Merge sort engine testbench
// Feeds sets of signed values over the input channel and checks each sorted
// run, with its last and dropped flags, against a shadow sort kept here.
// Directed sets cover the value extremes, ties and overflow.
// Random sets follow under changing idle and stall patterns, including one
// long receiver hold-off on a full set.
// ----------------------------------------------------------------------------
module tb_top;
  import mse_pkg::*;

  localparam int Depth             = DefMaxElements;
  localparam int HoldCycles        = 300;
  localparam int RandItemsPerPhase = 4;
  localparam int LimitCycles       = 200_000;

  typedef struct {
    mse_value_t value;
    logic       last;
    logic       dropped;
  } sort_result_t;

  // One directed row: value sent reps times; typed rows carry their own
  // single-element answer.
  typedef struct {
    mse_value_t value;
    logic       last;
    int         reps;
    logic       typed;
    mse_value_t exp_value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  merge_sort_engine dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the set being collected
  mse_value_t   shadow_store [Depth];
  int           shadow_count = 0;
  logic         shadow_overflow = 1'b0;
  sort_result_t sorted_run [$];
  sort_result_t sorted_due [$];

  int mismatch_count = 0;
  int src_idle_pct   = 0;
  int stall_pct      = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  stim_row_t dir_rows [18] = '{
    '{32'sh8000_0000, 1'b1, 1,  1'b1, 32'sh8000_0000},
    '{32'sh7fff_ffff, 1'b1, 1,  1'b1, 32'sh7fff_ffff},
    '{0,              1'b1, 1,  1'b1, 0},
    '{-1,             1'b1, 1,  1'b1, -1},
    '{5,              1'b0, 1,  1'b0, 0},
    '{32'sh8000_0000, 1'b0, 1,  1'b0, 0},
    '{32'sh7fff_ffff, 1'b0, 1,  1'b0, 0},
    '{-1,             1'b0, 1,  1'b0, 0},
    '{0,              1'b0, 1,  1'b0, 0},
    '{5,              1'b1, 1,  1'b0, 0},
    '{3,              1'b0, 1,  1'b0, 0},
    '{2,              1'b0, 1,  1'b0, 0},
    '{1,              1'b1, 1,  1'b0, 0},
    '{-2,             1'b0, 1,  1'b0, 0},
    '{-2,             1'b1, 1,  1'b0, 0},
    // overflow: the tail and the element with last are discarded
    '{1,              1'b0, 64, 1'b0, 0},
    '{2,              1'b0, 1,  1'b0, 0},
    '{-1,             1'b1, 1,  1'b0, 0}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Store one element; on last, sort the set (stable) into sorted_run
  function automatic void load_and_sort(input mse_value_t v, input logic lst);
    mse_value_t key;
    int         j;
    sorted_run.delete();
    if (shadow_count < Depth) begin
      shadow_store[shadow_count] = v;
      shadow_count++;
    end else begin
      shadow_overflow = 1'b1;
    end
    if (!lst) return;
    for (int i = 1; i < shadow_count; i++) begin
      key = shadow_store[i];
      j = i - 1;
      // strict compare keeps equal keys in arrival order
      while (j >= 0 && shadow_store[j] > key) begin
        shadow_store[j+1] = shadow_store[j];
        j--;
      end
      shadow_store[j+1] = key;
    end
    for (int i = 0; i < shadow_count; i++)
      sorted_run.push_back('{shadow_store[i], i == shadow_count - 1, shadow_overflow});
    shadow_count    = 0;
    shadow_overflow = 1'b0;
  endfunction

  function automatic mse_value_t rand_elem();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $signed($urandom_range(8)) - 4;  // dense range, many ties
      default: return $urandom;
    endcase
  endfunction

  task automatic set_pacing(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    stall_pct   <= snk_pct;
  endtask

  // Called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input mse_value_t v, input logic lst, input logic typed,
                           input mse_value_t exp_v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    in_ch.last_in  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    load_and_sort(v, lst);
    if (typed)
      sorted_due.push_back('{exp_v, 1'b1, 1'b0});
    else
      foreach (sorted_run[i]) sorted_due.push_back(sorted_run[i]);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++)
      send_item(rand_elem(), i == n - 1, 1'b0, 0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    sort_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result: value=%0d last=%0b dropped=%0b", $time,
                 out_ch.value_out, out_ch.last_out, out_ch.dropped);
        mismatch_count++;
      end else begin
        want = sorted_due.pop_front();
        if (out_ch.value_out !== want.value || out_ch.last_out !== want.last ||
            out_ch.dropped !== want.dropped) begin
          $display("%0t: result mismatch: expected value=%0d last=%0b dropped=%0b,",
                   $time, want.value, want.last, want.dropped,
                   " got value=%0d last=%0b dropped=%0b",
                   out_ch.value_out, out_ch.last_out, out_ch.dropped);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int src_tab [4];
    int snk_tab [4];
    int n;
    int sent;
    src_tab        = '{0, 56, 0, 17};
    snk_tab        = '{0, 0, 56, 17};
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value_in = '0;
    in_ch.last_in  = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_pacing(17, 17);
    foreach (dir_rows[i])
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_item(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                  dir_rows[i].exp_value);

    for (int ph = 0; ph < 4; ph++) begin
      set_pacing(src_tab[ph], snk_tab[ph]);
      if (ph == 0) begin
        // receiver holds off while an exactly full set and the next one are offered
        hold_token <= hold_token + 1;
        send_set(Depth);
        send_set(3);
      end
      sent = 0;
      while (sent < RandItemsPerPhase) begin
        n = $urandom_range(RandItemsPerPhase - sent, 1);
        send_set(n);
        sent += n;
      end
    end
    in_ch.valid <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk);
    repeat (2 * Depth) @(posedge clk);
    if (mismatch_count == 0)
      $display("** merge_sort_engine: PASSED **");
    else
      $display("** merge_sort_engine: FAILED **");
    $finish;
  end

  initial begin
    #(LimitCycles * 10);
    $display("** merge_sort_engine: FAILED **");
    $finish;
  end

endmodule
